>>> design/sphere_phong_pixel_shader_assert.svh
// Assertion macros for the sphere shader
`ifndef SPHERE_PHONG_PIXEL_SHADER_ASSERT_SVH
`define SPHERE_PHONG_PIXEL_SHADER_ASSERT_SVH
`ifndef SYNTHESIS
`define SPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SPS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPS_ASSERT(label, clk, rst, prop, msg)
`define SPS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> design/sps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg
// Shared constants and types of the sphere Phong pixel shader.
// ----------------------------------------------------------------------------
package sps_pkg;
   localparam int RADIUS_DEFAULT = 30;
   localparam int ONE_Q14        = 16384;
   localparam int SQRT_STEPS     = 15;   // bit pairs of the 30-bit radicand

   // register indexes
   typedef enum logic [2:0] {
      REG_LIGHT_X  = 3'd0,
      REG_LIGHT_Y  = 3'd1,
      REG_LIGHT_Z  = 3'd2,
      REG_DIFFUSE  = 3'd3,
      REG_LIGHT    = 3'd4,
      REG_AMBIENT  = 3'd5
   } reg_index_type;

   // isqrt state carried down the pipe
   typedef struct packed {
      logic [29:0] rem;
      logic [15:0] root;
   } sqrt_state_type;
endpackage

>>> design/sps_sqrt_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_sqrt_stage
// One result bit of a restoring integer square root (combinational).
// ----------------------------------------------------------------------------
module sps_sqrt_stage #(
   parameter int STEP = 0
) (
   input  sps_pkg::sqrt_state_type state_i,
   input  logic [29:0]             rad_i,
   output sps_pkg::sqrt_state_type state_o
);
   localparam int SH = 28 - 2 * STEP;
   logic [31:0] trial;
   logic [31:0] part;

   // bring down next two radicand bits and try root*4+1
   always_comb begin
      part  = {state_i.rem, rad_i[SH +: 2]};
      trial = {14'd0, state_i.root, 2'b01};
      if (part >= trial) begin
         state_o.rem  = 30'(part - trial);
         state_o.root = {state_i.root[14:0], 1'b1};
      end else begin
         state_o.rem  = part[29:0];
         state_o.root = {state_i.root[14:0], 1'b0};
      end
   end
endmodule

>>> design/sphere_phong_pixel_shader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_phong_pixel_shader
// Phong shading of a sphere disc centred in a square tile.
// ----------------------------------------------------------------------------
// Usage: send one pixel (req_pixel_col/row) per req transfer; one rsp transfer
// returns red/green/blue and on_disc for it, in order. Pixels outside the
// disc are black with on_disc low.
// Throughput: one pixel per clock unless stalled. Pipeline: 24 register
// stages: three stages for the normal (disc test, scaling, radicand),
// eight square root stages of two bits each (one in the last), two for
// the dot product, two for the reflection, six specular power stages,
// the color multiply, saturation and the output register.
// Stalls: when rsp_valid is high and rsp_ready low the whole pipe holds;
// req_ready is high whenever the output stage is empty or being taken, so
// a full pipe keeps accepting while the receiver takes results.
// Reset: clears all valid bits and loads the register defaults (light along
// +z, diffuse 0x646464, light 0xC8C8C8, ambient 0x141414).
// Configuration: APB write to byte address 4*i; write only while idle.
// ----------------------------------------------------------------------------
`include "sphere_phong_pixel_shader_assert.svh"
module sphere_phong_pixel_shader #(
   parameter int RADIUS = sps_pkg::RADIUS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [5:0]  req_pixel_col,
   input  logic [5:0]  req_pixel_row,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_on_disc,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int NST   = 24;
   localparam int R2    = RADIUS * RADIUS;
   // reciprocal for x*16384/RADIUS, exact over |x|<=RADIUS
   localparam int RSH   = 24;
   localparam longint RECIP = ((64'd16384 << RSH) + RADIUS - 1) / RADIUS;

   // ---------------- configuration registers ----------------
   logic signed [15:0] lx_ff, ly_ff, lz_ff;
   logic [23:0]        dif_ff, lrgb_ff, amb_ff;
   logic               wr_en;
   sps_pkg::reg_index_type widx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign widx   = sps_pkg::reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         lx_ff   <= '0;
         ly_ff   <= '0;
         lz_ff   <= 16'(sps_pkg::ONE_Q14);
         dif_ff  <= 24'h646464;
         lrgb_ff <= 24'hC8C8C8;
         amb_ff  <= 24'h141414;
      end else if (wr_en) begin
         case (widx)
            sps_pkg::REG_LIGHT_X: lx_ff   <= pwdata[15:0];
            sps_pkg::REG_LIGHT_Y: ly_ff   <= pwdata[15:0];
            sps_pkg::REG_LIGHT_Z: lz_ff   <= pwdata[15:0];
            sps_pkg::REG_DIFFUSE: dif_ff  <= pwdata[23:0];
            sps_pkg::REG_LIGHT:   lrgb_ff <= pwdata[23:0];
            sps_pkg::REG_AMBIENT: amb_ff  <= pwdata[23:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (widx)
         sps_pkg::REG_LIGHT_X: prdata = {{16{lx_ff[15]}}, lx_ff};
         sps_pkg::REG_LIGHT_Y: prdata = {{16{ly_ff[15]}}, ly_ff};
         sps_pkg::REG_LIGHT_Z: prdata = {{16{lz_ff[15]}}, lz_ff};
         sps_pkg::REG_DIFFUSE: prdata = {8'd0, dif_ff};
         sps_pkg::REG_LIGHT:   prdata = {8'd0, lrgb_ff};
         sps_pkg::REG_AMBIENT: prdata = {8'd0, amb_ff};
         default:              prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic [NST-1:0] vld_ff;
   logic           adv;

   assign adv       = ~vld_ff[NST-1] | rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   // ---------------- stage 0: centered coordinates, disc test ----------------
   logic signed [8:0]  xf, yf;
   logic [17:0]        dist2;
   logic signed [8:0]  xf_ff, yf_ff;
   logic               on0_ff;

   always_comb begin
      xf    = 9'($signed({3'd0, req_pixel_col})) - 9'(RADIUS);
      yf    = 9'($signed({3'd0, req_pixel_row})) - 9'(RADIUS);
      dist2 = 18'(xf * xf) + 18'(yf * yf);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xf_ff  <= xf;
         yf_ff  <= yf;
         on0_ff <= (32'(dist2) <= 32'(R2));
      end
   end

   // ---------------- stage 1: vx, vy by reciprocal multiply ----------------
   function automatic logic signed [15:0] scale_q14(input logic signed [8:0] v);
      logic [7:0]  mag;
      logic [47:0] prod;
      logic [15:0] q;
      mag  = v[8] ? 8'(-v) : 8'(v);
      prod = 48'(mag) * 48'(RECIP);
      q    = 16'(prod >> RSH);
      return v[8] ? -$signed(q) : $signed(q);
   endfunction

   logic signed [15:0] vx1_ff, vy1_ff;
   logic               on1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         vx1_ff <= scale_q14(xf_ff);
         vy1_ff <= scale_q14(yf_ff);
         on1_ff <= on0_ff;
      end
   end

   // ---------------- stage 2: radicand ----------------
   logic signed [31:0] sqx, sqy, radv;
   logic [29:0]        rad2_ff;
   logic signed [15:0] vx2_ff, vy2_ff;
   logic               on2_ff;
   always_comb begin
      sqx  = vx1_ff * vx1_ff;
      sqy  = vy1_ff * vy1_ff;
      radv = 32'sd268435456 - sqx - sqy;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rad2_ff <= radv[31] ? '0 : radv[29:0];
         vx2_ff  <= vx1_ff;
         vy2_ff  <= vy1_ff;
         on2_ff  <= on1_ff;
      end
   end

   // ---------------- stages 3..10: square root, two bits per stage, one in the last ----------
   localparam int SQS = 8;
   sps_pkg::sqrt_state_type sq_ff [SQS];
   logic [29:0]             srad_ff [SQS];
   logic signed [15:0]      svx_ff [SQS];
   logic signed [15:0]      svy_ff [SQS];
   logic                    son_ff [SQS];

   genvar g;
   generate
      for (g = 0; g < SQS; g++) begin : g_sqrt
         sps_pkg::sqrt_state_type st_s, a_s, b_s;
         logic [29:0]             rad_s;
         logic signed [15:0]      vx_s, vy_s;
         logic                    on_s;
         // stage input: radicand stage first, then the previous root stage
         if (g == 0) begin : g_head
            assign st_s  = '0;
            assign rad_s = rad2_ff;
            assign vx_s  = vx2_ff;
            assign vy_s  = vy2_ff;
            assign on_s  = on2_ff;
         end else begin : g_body
            assign st_s  = sq_ff[g-1];
            assign rad_s = srad_ff[g-1];
            assign vx_s  = svx_ff[g-1];
            assign vy_s  = svy_ff[g-1];
            assign on_s  = son_ff[g-1];
         end
         sps_sqrt_stage #(.STEP(2 * g)) u_a (
            .state_i(st_s), .rad_i(rad_s), .state_o(a_s));
         // second step only while radicand bit pairs remain
         if (2 * g + 1 < sps_pkg::SQRT_STEPS) begin : g_odd
            sps_sqrt_stage #(.STEP(2 * g + 1)) u_b (
               .state_i(a_s), .rad_i(rad_s), .state_o(b_s));
         end else begin : g_last
            assign b_s = a_s;
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               sq_ff[g]   <= b_s;
               srad_ff[g] <= rad_s;
               svx_ff[g]  <= vx_s;
               svy_ff[g]  <= vy_s;
               son_ff[g]  <= on_s;
            end
         end
      end
   endgenerate

   // ---------------- stage 11: products with light ----------------
   logic signed [16:0] vz;
   logic signed [32:0] px_ff, py_ff, pz_ff;
   logic signed [16:0] vz11_ff;
   logic               on11_ff;
   assign vz = $signed({1'b0, sq_ff[SQS-1].root});
   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff   <= 33'(svx_ff[SQS-1] * lx_ff);
         py_ff   <= 33'(svy_ff[SQS-1] * ly_ff);
         pz_ff   <= 33'(vz * lz_ff);
         vz11_ff <= vz;
         on11_ff <= son_ff[SQS-1];
      end
   end

   // ---------------- stage 12: NL ----------------
   logic signed [34:0] dot;
   logic signed [20:0] nl12_ff;
   logic signed [16:0] vz12_ff;
   logic               on12_ff;
   assign dot = 35'(px_ff) + 35'(py_ff) + 35'(pz_ff);
   always_ff @(posedge clock) begin
      if (adv) begin
         nl12_ff <= 21'(dot >>> 14);
         vz12_ff <= vz11_ff;
         on12_ff <= on11_ff;
      end
   end

   // ---------------- stage 13: 2*vz*NL ----------------
   logic signed [38:0] vznl_ff;
   logic signed [20:0] nl13_ff;
   logic               on13_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         vznl_ff <= 39'(vz12_ff * nl12_ff) <<< 1;
         nl13_ff <= nl12_ff;
         on13_ff <= on12_ff;
      end
   end

   // ---------------- stage 14: rz, clamp specular base ----------------
   logic signed [26:0] negrz;
   logic [14:0]        s14_ff;
   logic [16:0]        nlc14_ff;
   logic               on14_ff;
   assign negrz = 27'(vznl_ff >>> 14) - 27'(lz_ff);
   always_ff @(posedge clock) begin
      if (adv) begin
         if (negrz[26])                s14_ff <= '0;
         else if (negrz > 27'sd16384)  s14_ff <= 15'(sps_pkg::ONE_Q14);
         else                          s14_ff <= negrz[14:0];
         // diffuse term clamps only at zero
         nlc14_ff <= nl13_ff[20] ? '0 : nl13_ff[16:0];
         on14_ff  <= on13_ff;
      end
   end

   // ---------------- stages 15..20: specular power ----------------
   logic [14:0] s2_ff, s4_ff, s8_ff, s16_ff, s24_ff, s25_ff, s8d_ff;
   logic [14:0] sd_ff [5];
   logic [16:0] nld_ff [6];
   logic        ond_ff [6];
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff  <= 15'((30'(s14_ff) * 30'(s14_ff)) >> 14);
         s4_ff  <= 15'((30'(s2_ff) * 30'(s2_ff)) >> 14);
         s8_ff  <= 15'((30'(s4_ff) * 30'(s4_ff)) >> 14);
         s16_ff <= 15'((30'(s8_ff) * 30'(s8_ff)) >> 14);
         s24_ff <= 15'((30'(s16_ff) * 30'(s8d_ff)) >> 14);
         s25_ff <= 15'((30'(s24_ff) * 30'(sd_ff[4])) >> 14);
         sd_ff[0] <= s14_ff;
         for (int i = 1; i < 5; i++) sd_ff[i] <= sd_ff[i-1];
         s8d_ff <= s8_ff;
         nld_ff[0] <= nlc14_ff;
         ond_ff[0] <= on14_ff;
         for (int i = 1; i < 6; i++) begin
            nld_ff[i] <= nld_ff[i-1];
            ond_ff[i] <= ond_ff[i-1];
         end
      end
   end

   // ---------------- stage 21: channel products ----------------
   logic [22:0] cr_ff, cg_ff, cb_ff;
   logic [23:0] amb21_ff;
   logic        on21_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         cr_ff <= 23'(((32'(dif_ff[23:16]) * 32'(nld_ff[5]))
                  + (32'(lrgb_ff[23:16]) * 32'(s25_ff))) >> 14);
         cg_ff <= 23'(((32'(dif_ff[15:8]) * 32'(nld_ff[5]))
                  + (32'(lrgb_ff[15:8]) * 32'(s25_ff))) >> 14);
         cb_ff <= 23'(((32'(dif_ff[7:0]) * 32'(nld_ff[5]))
                  + (32'(lrgb_ff[7:0]) * 32'(s25_ff))) >> 14);
         amb21_ff <= amb_ff;
         on21_ff  <= ond_ff[5];
      end
   end

   // ---------------- stage 22..23: add ambient, saturate, output ----------------
   function automatic logic [7:0] sat8(input logic [22:0] c, input logic [7:0] a);
      logic [23:0] t;
      t = 24'(c) + 24'(a);
      return (t > 24'd255) ? 8'hFF : t[7:0];
   endfunction

   logic [7:0] r22_ff, g22_ff, b22_ff;
   logic       on22_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         r22_ff  <= on21_ff ? sat8(cr_ff, amb21_ff[23:16]) : '0;
         g22_ff  <= on21_ff ? sat8(cg_ff, amb21_ff[15:8])  : '0;
         b22_ff  <= on21_ff ? sat8(cb_ff, amb21_ff[7:0])   : '0;
         on22_ff <= on21_ff;
         rsp_red     <= r22_ff;
         rsp_green   <= g22_ff;
         rsp_blue    <= b22_ff;
         rsp_on_disc <= on22_ff;
      end
   end

   // ---------------- assertions ----------------
   `SPS_ASSERT(a_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result lost in stall")
   `SPS_ASSERT(a_black, clock, reset, rsp_valid && !rsp_on_disc |-> rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0, "off-disc pixel not black")
   `SPS_ASSERT(a_rdy, clock, reset, !rsp_valid |-> req_ready, "input blocked with empty output")
endmodule

>>> sim/tb_sphere_phong_pixel_shader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sphere_phong_pixel_shader
// Self-checking bench for the sphere Phong pixel shader: directed pixels
// (disc edges, center, tile extremes, off-tile coordinates) and random
// pixels under several light and color settings, with random gaps on both
// channels and one long receiver hold-off. Each result is compared with a
// bit-exact shading predictor or, for typed-in directed pixels, with black.
// ----------------------------------------------------------------------------
module tb_sphere_phong_pixel_shader;

   localparam int RAD       = sps_pkg::RADIUS_DEFAULT;
   localparam int LIMIT_CYC = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [5:0]  req_pixel_col = '0;
   logic [5:0]  req_pixel_row = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red, rsp_green, rsp_blue;
   logic        rsp_on_disc;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       on_disc;
   } pixel_color_type;

   typedef struct {
      logic [5:0]      col;
      logic [5:0]      row;
      logic            known;
      pixel_color_type color;
   } pixel_row_type;

   // shading setup mirrored from the register writes
   logic signed [15:0] lit_x, lit_y, lit_z;
   logic [23:0]        dif_rgb, spc_rgb, amb_rgb;

   pixel_color_type color_queue[$];
   int unsigned  cycle_cnt = 0;
   int unsigned  n_fail = 0, n_pix = 0, n_disc = 0;
   int           send_idle_pct = 0, recv_stall_pct = 0;
   bit           hold_off = 1'b0;

   // light vectors of the sweep
   int lights[6][3] = '{'{0, 0, 16384}, '{16384, 0, 0}, '{-16384, 0, 0},
                        '{0, -16384, 0}, '{9459, 9459, -9459},
                        '{-9459, 9459, 9459}};

   sphere_phong_pixel_shader u_dut (.*);

   always #10 clock = ~clock;

   // integer square root, bit by bit
   function automatic longint isqrt(longint n);
      longint res, bitv;
      res = 0; bitv = 64'd1 << 30;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint chan_shade(logic [7:0] d, logic [7:0] l, logic [7:0] a,
                                         longint nl, longint spec);
      longint c;
      c = ((longint'(d) * nl + longint'(l) * spec) >>> 14) + longint'(a);
      return (c > 255) ? 255 : c;
   endfunction

   // expected color of one pixel under the current setup
   function automatic pixel_color_type shade_pixel(logic [5:0] col, logic [5:0] row);
      pixel_color_type c;
      longint xf, yf, vx, vy, vz, rad, nl, rz, s, s2, s4, s8, s16, spec, nlc;
      c = '0;
      xf = longint'(col) - RAD;
      yf = longint'(row) - RAD;
      if (xf * xf + yf * yf > RAD * RAD) return c;
      vx = (xf * 16384) / RAD;
      vy = (yf * 16384) / RAD;
      rad = (64'sd1 <<< 28) - vx * vx - vy * vy;
      if (rad < 0) rad = 0;
      vz = isqrt(rad);
      nl = (vx * lit_x + vy * lit_y + vz * lit_z) >>> 14;
      rz = lit_z - ((2 * vz * nl) >>> 14);
      s = -rz;
      if (s < 0) s = 0;
      if (s > 16384) s = 16384;
      s2 = (s * s) >> 14;
      s4 = (s2 * s2) >> 14;
      s8 = (s4 * s4) >> 14;
      s16 = (s8 * s8) >> 14;
      spec = (((s16 * s8) >> 14) * s) >> 14;
      nlc = (nl > 0) ? nl : 0;
      c.red   = 8'(chan_shade(dif_rgb[23:16], spc_rgb[23:16], amb_rgb[23:16], nlc, spec));
      c.green = 8'(chan_shade(dif_rgb[15:8], spc_rgb[15:8], amb_rgb[15:8], nlc, spec));
      c.blue  = 8'(chan_shade(dif_rgb[7:0], spc_rgb[7:0], amb_rgb[7:0], nlc, spec));
      c.on_disc = 1'b1;
      return c;
   endfunction

   // cycle limit
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > LIMIT_CYC) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result check on each rsp transfer
   always @(posedge clock) begin
      pixel_color_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (color_queue.size() == 0) begin
            $error("unexpected result transfer");
            n_fail++;
         end else begin
            want = color_queue.pop_front();
            if (rsp_red != want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_red); n_fail++;
            end
            if (rsp_green != want.green) begin
               $error("green: expected %0d, got %0d", want.green, rsp_green); n_fail++;
            end
            if (rsp_blue != want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, rsp_blue); n_fail++;
            end
            if (rsp_on_disc != want.on_disc) begin
               $error("on_disc: expected %0d, got %0d", want.on_disc, rsp_on_disc);
               n_fail++;
            end
            if (rsp_on_disc) n_disc++;
         end
      end
   end

   // receiver: random stalls, plus the long hold-off
   always @(negedge clock) begin
      if (hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic csr_write(sps_pkg::reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= 5'(idx) << 2; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         sps_pkg::REG_LIGHT_X: lit_x = value[15:0];
         sps_pkg::REG_LIGHT_Y: lit_y = value[15:0];
         sps_pkg::REG_LIGHT_Z: lit_z = value[15:0];
         sps_pkg::REG_DIFFUSE: dif_rgb = value[23:0];
         sps_pkg::REG_LIGHT:   spc_rgb = value[23:0];
         sps_pkg::REG_AMBIENT: amb_rgb = value[23:0];
         default: ;
      endcase
   endtask

   task automatic set_light(int lx, int ly, int lz);
      csr_write(sps_pkg::REG_LIGHT_X, 32'(lx));
      csr_write(sps_pkg::REG_LIGHT_Y, 32'(ly));
      csr_write(sps_pkg::REG_LIGHT_Z, 32'(lz));
   endtask

   // one pixel transfer; sender gap before it; typed color when known
   task automatic send_pixel(logic [5:0] col, logic [5:0] row, bit known,
                             pixel_color_type color);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1; req_pixel_col <= col; req_pixel_row <= row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      color_queue.push_back(known ? color : shade_pixel(col, row));
      n_pix++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (color_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      @(negedge clock);
   endtask

   // pixel with a bias toward the disc
   task automatic random_pixels(int count);
      logic [5:0] c, r;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) < 8) begin
            c = 6'($urandom_range(59)); r = 6'($urandom_range(59));
         end else begin
            c = 6'($urandom); r = 6'($urandom);
         end
         send_pixel(c, r, 1'b0, '0);
      end
   endtask

   pixel_row_type directed[$];

   initial begin
      pixel_row_type pr;
      lit_x = 0; lit_y = 0; lit_z = 16384;
      dif_rgb = 24'h646464; spc_rgb = 24'hC8C8C8; amb_rgb = 24'h141414;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table: off-disc rows carry typed-in black
      directed = '{
         '{6'd0,  6'd0,  1'b1, '0}, '{6'd59, 6'd59, 1'b1, '0},
         '{6'd63, 6'd63, 1'b1, '0}, '{6'd0,  6'd59, 1'b1, '0},
         '{6'd63, 6'd30, 1'b1, '0}, '{6'd30, 6'd30, 1'b0, '0},
         '{6'd0,  6'd30, 1'b0, '0}, '{6'd30, 6'd0,  1'b0, '0},
         '{6'd59, 6'd30, 1'b0, '0}, '{6'd30, 6'd59, 1'b0, '0},
         '{6'd9,  6'd9,  1'b0, '0}, '{6'd51, 6'd51, 1'b0, '0},
         '{6'd8,  6'd8,  1'b1, '0}, '{6'd31, 6'd29, 1'b0, '0},
         '{6'd42, 6'd21, 1'b0, '0}, '{6'd21, 6'd42, 1'b0, '0}};
      foreach (directed[i]) begin
         pr = directed[i];
         send_pixel(pr.col, pr.row, pr.known, pr.color);
      end
      drain();

      // light sweep with random pixels under each idling mix
      for (int ph = 0; ph < 6; ph++) begin
         set_light(lights[ph][0], lights[ph][1], lights[ph][2]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         if (ph == 1) begin
            csr_write(sps_pkg::REG_DIFFUSE, 32'hFFFFFF);
            csr_write(sps_pkg::REG_LIGHT, 32'hFFFFFF);
            csr_write(sps_pkg::REG_AMBIENT, 32'hFFFFFF);
         end else if (ph == 2) begin
            csr_write(sps_pkg::REG_DIFFUSE, 32'h000000);
            csr_write(sps_pkg::REG_LIGHT, 32'h000000);
            csr_write(sps_pkg::REG_AMBIENT, 32'h000000);
         end else if (ph >= 3) begin
            csr_write(sps_pkg::REG_DIFFUSE, $urandom);
            csr_write(sps_pkg::REG_LIGHT, $urandom);
            csr_write(sps_pkg::REG_AMBIENT, $urandom);
         end
         random_pixels(150);
         drain();
      end

      // long receiver hold-off while pixels keep coming
      send_idle_pct = 0; recv_stall_pct = 0;
      hold_off = 1'b1;
      fork
         begin repeat (200) @(posedge clock); hold_off = 1'b0; end
         random_pixels(60);
      join
      drain();

      // non-unit and random light vectors, random ambient color
      for (int ph = 0; ph < 3; ph++) begin
         set_light($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
         csr_write(sps_pkg::REG_AMBIENT, $urandom);
         send_idle_pct = 30; recv_stall_pct = 30;
         random_pixels(50);
         drain();
      end

      $display("Shaded %0d pixels (%0d on the disc) under 9 light setups,",
               n_pix, n_disc);
      $display("with random gaps, stalls and one long result hold-off.");
      if (n_fail == 0 && color_queue.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

>>> sphere_phong_pixel_shader.f
+incdir+design
design/sps_pkg.sv
design/sps_sqrt_stage.sv
design/sphere_phong_pixel_shader.sv
sim/tb_sphere_phong_pixel_shader.sv
